// ===== rtl/core/cxab_pkg.sv =====
// Shared constants and types for the chaining byte cipher.
package cxab_pkg;

    localparam int BLOCK_BYTES_DEF = 8;
    localparam int BYTE_W          = 8;
    localparam int BLOCK_W         = 64;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 64;

    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_VECTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAIN_KEY       = 2'd2;

    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    typedef struct packed {
        logic               direction;
        logic [BLOCK_W-1:0] initial_vector;
        logic [BLOCK_W-1:0] main_key;
    } cfg_t;

    typedef struct packed {
        logic              direction;
        logic [BYTE_W-1:0] cipher;
        logic [BYTE_W-1:0] key;
        logic [BYTE_W-1:0] chain;
    } work_t;

endpackage

// ===== rtl/core/cxab_ifs.sv =====
// Valid/ready channel interfaces: input words, result words, register writes.
interface cxab_in_if;
    logic                       valid;
    logic                       ready;
    logic [cxab_pkg::BYTE_W-1:0] data_byte;
    logic                       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface cxab_out_if;
    logic                       valid;
    logic                       ready;
    logic [cxab_pkg::BYTE_W-1:0] result_byte;

    modport source (output valid, output result_byte, input ready);
    modport sink   (input valid, input result_byte, output ready);
endinterface

interface cxab_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cxab_pkg::CFG_IDX_W-1:0]  index;
    logic [cxab_pkg::CFG_DATA_W-1:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/core/cxab_chain.sv =====
// Front stage: byte position, chain store and the chained encrypt step.
module cxab_chain #(
    parameter int BLOCK_BYTES = cxab_pkg::BLOCK_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [cxab_pkg::BYTE_W-1:0] data_byte,
    input  logic                        first_byte,
    input  cxab_pkg::cfg_t              cfg,
    output cxab_pkg::work_t             work
);

    localparam int IDX_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(BLOCK_BYTES - 1);

    logic [IDX_W-1:0]            pos_reg;
    logic [IDX_W-1:0]            pos_next;
    logic [IDX_W-1:0]            pos_cur;
    logic [cxab_pkg::BYTE_W-1:0] chain_reg  [BLOCK_BYTES];
    logic [cxab_pkg::BYTE_W-1:0] chain_next [BLOCK_BYTES];
    logic [cxab_pkg::BYTE_W-1:0] chain_rd;
    logic [cxab_pkg::BYTE_W-1:0] key_b;
    logic [cxab_pkg::BYTE_W-1:0] enc_c;
    logic [cxab_pkg::BYTE_W-1:0] cipher;

    assign pos_cur  = first_byte ? '0 : pos_reg;
    assign chain_rd = first_byte ? cfg.initial_vector[cxab_pkg::BYTE_W-1:0]
                                 : chain_reg[pos_cur];
    assign key_b    = cfg.main_key[{pos_cur, 3'b000} +: cxab_pkg::BYTE_W];
    assign enc_c    = (data_byte ^ chain_rd) + key_b;
    assign cipher   = (cfg.direction == cxab_pkg::DIR_DECRYPT) ? data_byte : enc_c;
    assign pos_next = (pos_cur == LAST_POS) ? '0 : pos_cur + 1'b1;

    always_comb
    begin
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            if (IDX_W'(i) == pos_cur)
            begin
                chain_next[i] = cipher;
            end
            else if (first_byte)
            begin
                chain_next[i] = cfg.initial_vector[i*cxab_pkg::BYTE_W +: cxab_pkg::BYTE_W];
            end
            else
            begin
                chain_next[i] = chain_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
        end
    end

    // chain bytes hold nothing meaningful until a first byte loads the vector
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < BLOCK_BYTES; i++)
            begin
                chain_reg[i] <= chain_next[i];
            end
        end
    end

    assign work.direction = cfg.direction;
    assign work.cipher    = cipher;
    assign work.key       = key_b;
    assign work.chain     = chain_rd;

endmodule

// ===== rtl/core/cbc_xor_add_byte_cipher.sv =====
// Top level of the chaining byte cipher: registers and the three-stage datapath.
// One result word per input word, in order. Sustained rate is one word per
// clock while result.ready stays high. Each word moves through work1_reg,
// val2_reg and res3_reg, and its result is held until result.ready takes it.
// The chain store update (encrypt: xor then add of the key byte; decrypt: the input
// byte as is) closes in the input cycle, since the next byte may chain from it; the
// decrypt subtract and xor follow in two further register stages. A first_byte
// word restarts the position at zero and reloads the chain from initial_vector.
// Registers: 0 direction (0 encrypt, 1 decrypt), 1 initial_vector, 2 main_key;
// byte i of a 64-bit register sits in bits 8i+7..8i. Write only while idle.
module cbc_xor_add_byte_cipher #(
    parameter int BLOCK_BYTES = cxab_pkg::BLOCK_BYTES_DEF
) (
    input logic        clk,
    input logic        rst_n,
    cxab_in_if.sink    feed,
    cxab_out_if.source result,
    cxab_cfg_if.sink   cfg
);

    cxab_pkg::cfg_t  cfg_reg;
    cxab_pkg::work_t work_s0;
    cxab_pkg::work_t work1_reg;

    logic                        v1_reg;
    logic                        v2_reg;
    logic                        v3_reg;
    logic                        dir2_reg;
    logic [cxab_pkg::BYTE_W-1:0] val2_reg;
    logic [cxab_pkg::BYTE_W-1:0] chain2_reg;
    logic [cxab_pkg::BYTE_W-1:0] res3_reg;
    logic [cxab_pkg::BYTE_W-1:0] val2_next;
    logic [cxab_pkg::BYTE_W-1:0] res3_next;
    logic                        en1;
    logic                        en2;
    logic                        en3;
    logic                        accept;

    // register writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                cxab_pkg::REG_DIRECTION:      cfg_reg.direction      <= cfg.wdata[0];
                cxab_pkg::REG_INITIAL_VECTOR: cfg_reg.initial_vector <= cfg.wdata;
                cxab_pkg::REG_MAIN_KEY:       cfg_reg.main_key       <= cfg.wdata;
                default:                      cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // stage flow
    assign en3        = !v3_reg || result.ready;
    assign en2        = !v2_reg || en3;
    assign en1        = !v1_reg || en2;
    assign feed.ready = en1;
    assign accept     = feed.valid && en1;

    cxab_chain #(
        .BLOCK_BYTES(BLOCK_BYTES)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (feed.data_byte),
        .first_byte (feed.first_byte),
        .cfg        (cfg_reg),
        .work       (work_s0)
    );

    assign val2_next = (work1_reg.direction == cxab_pkg::DIR_DECRYPT)
                       ? work1_reg.cipher - work1_reg.key : work1_reg.cipher;
    assign res3_next = (dir2_reg == cxab_pkg::DIR_DECRYPT) ? val2_reg ^ chain2_reg : val2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= feed.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            work1_reg <= work_s0;
        end
        if (en2 && v1_reg)
        begin
            dir2_reg   <= work1_reg.direction;
            val2_reg   <= val2_next;
            chain2_reg <= work1_reg.chain;
        end
        if (en3 && v2_reg)
        begin
            res3_reg <= res3_next;
        end
    end

    assign result.valid       = v3_reg;
    assign result.result_byte = res3_reg;

endmodule

// ===== dv/cbc_xor_add_byte_cipher_test.sv =====
// Testbench for the chaining byte cipher: directed corners, random messages, per-word checks.
`timescale 1ns / 1ps

module cbc_xor_add_byte_cipher_test;

    localparam logic [cxab_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int unsigned RANDOM_WORDS = 1650;
    localparam int unsigned DRAIN_CYCLES = 8;

    class cipher_chain_tracker;
        logic                          direction;
        logic [cxab_pkg::BLOCK_W-1:0]  initial_vector;
        logic [cxab_pkg::BLOCK_W-1:0]  main_key;
        logic [cxab_pkg::BYTE_W-1:0]   chain_block [cxab_pkg::BLOCK_BYTES_DEF];
        int unsigned                   byte_position;
        logic [cxab_pkg::BYTE_W-1:0]   predicted_bytes [$];
        int unsigned                   failures;

        function new();
            direction      = cxab_pkg::DIR_ENCRYPT;
            initial_vector = '0;
            main_key       = '0;
            foreach (chain_block[i])
                chain_block[i] = '0;
            byte_position  = 0;
            failures       = 0;
        endfunction

        function void write_reg(logic [cxab_pkg::CFG_IDX_W-1:0] index,
                                logic [cxab_pkg::CFG_DATA_W-1:0] value);
            case (index)
                cxab_pkg::REG_DIRECTION:      direction = value[0];
                cxab_pkg::REG_INITIAL_VECTOR: initial_vector = value;
                cxab_pkg::REG_MAIN_KEY:       main_key = value;
                default: ;
            endcase
        endfunction

        function void take_word(logic [cxab_pkg::BYTE_W-1:0] data, logic first);
            logic [cxab_pkg::BYTE_W-1:0] key_byte;
            logic [cxab_pkg::BYTE_W-1:0] cipher_byte;
            logic [cxab_pkg::BYTE_W-1:0] out_byte;
            if (first)
            begin
                byte_position = 0;
                foreach (chain_block[i])
                    chain_block[i] = initial_vector[8*i +: 8];
            end
            key_byte = main_key[8*byte_position +: 8];
            if (direction == cxab_pkg::DIR_DECRYPT)
            begin
                cipher_byte = data;
                out_byte    = (data - key_byte) ^ chain_block[byte_position];
            end
            else
            begin
                out_byte    = (data ^ chain_block[byte_position]) + key_byte;
                cipher_byte = out_byte;
            end
            chain_block[byte_position] = cipher_byte;
            byte_position = (byte_position + 1 >= cxab_pkg::BLOCK_BYTES_DEF)
                            ? 0 : byte_position + 1;
            predicted_bytes = {predicted_bytes, out_byte};
        endfunction

        function void match_result(logic [cxab_pkg::BYTE_W-1:0] actual);
            logic [cxab_pkg::BYTE_W-1:0] wanted;
            if (predicted_bytes.size() == 0)
            begin
                $error("result_byte: expected none, actual %h", actual);
                failures++;
                return;
            end
            wanted = predicted_bytes.pop_front();
            if (actual !== wanted)
            begin
                $error("result_byte: expected %h, actual %h", wanted, actual);
                failures++;
            end
        endfunction

        function int unsigned pending();
            return predicted_bytes.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    cxab_in_if  feed_bus ();
    cxab_out_if result_bus ();
    cxab_cfg_if cfg_bus ();

    cbc_xor_add_byte_cipher dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    cipher_chain_tracker tracker = new();

    logic [cxab_pkg::BYTE_W-1:0] corner_bytes [10] = '{8'h00, 8'hff, 8'h80, 8'h7f, 8'h01,
                                                       8'hfe, 8'h55, 8'haa, 8'h00, 8'hff};
    bit          src_calm;
    bit          sink_calm;
    int unsigned words_sent;

    always #6 clk = ~clk;

    function automatic logic [cxab_pkg::BLOCK_W-1:0] pick_block();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic put_reg(logic [cxab_pkg::CFG_IDX_W-1:0] index,
                           logic [cxab_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= index;
        cfg_bus.wdata <= value;
        do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
        tracker.write_reg(index, value);
    endtask

    task automatic close_reg_writes();
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic send_word(logic [cxab_pkg::BYTE_W-1:0] data, logic first);
        int unsigned gap;
        gap = src_calm ? 0 : $urandom_range(0, 13);
        @(negedge clk);
        if (gap != 0)
        begin
            feed_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        feed_bus.valid      <= 1'b1;
        feed_bus.data_byte  <= data;
        feed_bus.first_byte <= first;
        do @(posedge clk); while (!(feed_bus.valid && feed_bus.ready));
        tracker.take_word(data, first);
        words_sent++;
    endtask

    task automatic settle();
        @(negedge clk);
        feed_bus.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase();
        int unsigned budget;
        int unsigned len;
        logic        fresh;
        budget    = $urandom_range(40, 220);
        if (budget > RANDOM_WORDS - words_sent)
            budget = RANDOM_WORDS - words_sent;
        src_calm  = ($urandom_range(0, 3) == 0);
        sink_calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 2) != 0)
            put_reg(cxab_pkg::REG_DIRECTION, {$urandom, $urandom});
        if ($urandom_range(0, 2) != 0)
            put_reg(cxab_pkg::REG_INITIAL_VECTOR, pick_block());
        if ($urandom_range(0, 2) != 0)
            put_reg(cxab_pkg::REG_MAIN_KEY, pick_block());
        if ($urandom_range(0, 7) == 0)
            put_reg(REG_UNUSED, {$urandom, $urandom});
        close_reg_writes();
        // a phase may pick up the old chain, so new registers land mid-message
        fresh = ($urandom_range(0, 3) != 0);
        while (budget != 0)
        begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 30);
            for (int unsigned i = 0; i < len && budget != 0; i++)
            begin
                send_word(8'($urandom_range(0, 255)), (i == 0) && fresh);
                budget--;
            end
            fresh = ($urandom_range(0, 7) != 0);
        end
        settle();
    endtask

    initial
    begin
        clk                 = 1'b0;
        rst_n               = 1'b0;
        feed_bus.valid      = 1'b0;
        feed_bus.data_byte  = '0;
        feed_bus.first_byte = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = '0;
        cfg_bus.wdata       = '0;
        words_sent          = 0;
        src_calm            = 1'b0;
        sink_calm           = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // encrypt: wrap past a block, short tail, restart mid-block, one-word message
        put_reg(cxab_pkg::REG_DIRECTION, {63'd0, cxab_pkg::DIR_ENCRYPT});
        put_reg(cxab_pkg::REG_INITIAL_VECTOR, '1);
        put_reg(cxab_pkg::REG_MAIN_KEY, 64'h0123_4567_89ab_cdef);
        put_reg(REG_UNUSED, '1);
        close_reg_writes();
        foreach (corner_bytes[i])
            send_word(corner_bytes[i], i == 0);
        send_word(8'h3c, 1'b1);
        send_word(8'hc3, 1'b0);
        send_word(8'h00, 1'b1);
        settle();

        sink_calm = 1'b0;
        put_reg(cxab_pkg::REG_DIRECTION, {63'd0, cxab_pkg::DIR_DECRYPT});
        put_reg(cxab_pkg::REG_MAIN_KEY, '1);
        put_reg(cxab_pkg::REG_INITIAL_VECTOR, '0);
        close_reg_writes();
        foreach (corner_bytes[i])
            send_word(corner_bytes[i], i == 0);
        settle();

        words_sent = 0;
        while (words_sent < RANDOM_WORDS)
            random_phase();
        settle();

        if (tracker.pending() != 0)
        begin
            $error("result_byte: %0d expected words never arrived", tracker.pending());
            tracker.failures++;
        end
        if (tracker.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int unsigned stall;
        result_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = sink_calm ? 0 : $urandom_range(0, 13);
            @(negedge clk);
            if (stall != 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_bus.ready <= 1'b1;
            do @(posedge clk); while (!(result_bus.valid && result_bus.ready));
            tracker.match_result(result_bus.result_byte);
        end
    end

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
